// ===== rtl/dbsg_pkg.sv =====
// Shared constants and types for the de Bruijn sequence generator.
package dbsg_pkg;

  localparam int MAX_ALPHABET = 8;
  localparam int MAX_ORDER    = 8;

  localparam int CFG_W    = 4;
  localparam int SYMBOL_W = 3;
  localparam int POS_W    = 24;
  localparam int APB_DW   = 32;
  localparam int APB_AW   = 3;
  localparam int S_TDATA_W = 8;
  localparam int M_TDATA_W = 32;
  localparam int M_PAD_W   = M_TDATA_W - POS_W - SYMBOL_W;

  // word store entry, symbol index and alphabet count widths
  localparam int WORD_W = (MAX_ALPHABET > 2) ? $clog2(MAX_ALPHABET) : 1;
  localparam int IDX_W  = $clog2(MAX_ORDER + 1);
  localparam int KW     = $clog2(MAX_ALPHABET + 1);

  typedef enum logic {
    REG_ALPHABET = 1'b0,
    REG_ORDER    = 1'b1
  } reg_index_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EXTEND
  } seq_state_t;

endpackage

// ===== rtl/de_bruijn_sequence_generator.sv =====
// Top level of the de Bruijn sequence generator: Lyndon-word sequencer and stream ports.
//
// Streams the lexicographically least de Bruijn cycle B(k, n), one symbol per input word,
// using the FKM construction: Lyndon words are visited in order and the symbols of every
// word whose length divides n are emitted. Each input word carries a restart flag
// (s_tdata[0]); each output word carries the symbol, its position in the cycle, and tlast
// on the final symbol of the k^n cycle, after which the sequence wraps to position zero.
// k and n come from APB registers alphabet_size (0x0) and order (0x4); writing either
// returns the sequence to position zero. A symbol inside the current Lyndon word is
// emitted straight from the idle state. The last symbol of a word (and every restart)
// waits for the successor search on the word store, one entry per cycle through a single
// read port: a downward scan from n to the position p to increment, then, when p < n, a
// periodic extension of entries p+1..n, repeated for each successor whose length does
// not divide n. The final symbol of the cycle scans all n entries before it wraps.
// Input is taken only while the sequencer is idle and the output register is free or
// being drained.
module de_bruijn_sequence_generator
  import dbsg_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // input stream
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // [0] restart, [7:1] zero
  // output stream
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,   // [2:0] symbol, [26:3] position, [31:27] zero
  output logic                 m_tlast,   // last symbol of the cycle
  // configuration
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [APB_AW-1:0]    paddr,
  input  logic [APB_DW-1:0]    pwdata,
  output logic [APB_DW-1:0]    prdata,
  output logic                 pready
);

  seq_state_t state, state_next;

  // configuration registers
  logic [CFG_W-1:0] alphabet_size;
  logic [CFG_W-1:0] order;

  // sequencer state
  logic [WORD_W-1:0] word [1:MAX_ORDER];
  logic [IDX_W-1:0]  word_length;
  logic [IDX_W-1:0]  emit_index;
  logic [POS_W-1:0]  position_count;

  // successor search
  logic [IDX_W-1:0]  scan_ptr;
  logic [IDX_W-1:0]  ext_i;
  logic [IDX_W-1:0]  ext_j;
  logic [WORD_W-1:0] hold_symbol;

  // output register
  logic [SYMBOL_W-1:0] out_symbol;
  logic [POS_W-1:0]    out_pos;
  logic                out_last;

  logic              accept;
  logic              restart;
  logic              cfg_wr;
  reg_index_t        cfg_index;
  logic [KW-1:0]     k_eff;
  logic [KW-1:0]     k_top;
  logic [IDX_W-1:0]  n_eff;
  logic [IDX_W-1:0]  rd_addr;
  logic [WORD_W-1:0] rd_data;
  logic              at_max;
  logic              period_end;
  logic              finish_ok;
  logic              finish_last;

  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign cfg_index = reg_index_t'(paddr[2]);
  assign prdata    = (cfg_index == REG_ORDER) ? APB_DW'(order) : APB_DW'(alphabet_size);

  assign s_tready = (state == ST_IDLE) && (!m_tvalid || m_tready);
  assign accept   = s_tvalid && s_tready;
  assign restart  = s_tdata[0];

  assign m_tdata = {M_PAD_W'(0), out_pos, out_symbol};
  assign m_tlast = out_last;

  // Clamp k into 2..MAX_ALPHABET and n into 1..MAX_ORDER.
  always_comb begin
    if (alphabet_size < CFG_W'(2)) begin
      k_eff = KW'(2);
    end else if (32'(alphabet_size) > MAX_ALPHABET) begin
      k_eff = KW'(MAX_ALPHABET);
    end else begin
      k_eff = KW'(alphabet_size);
    end
    if (order == '0) begin
      n_eff = IDX_W'(1);
    end else if (32'(order) > MAX_ORDER) begin
      n_eff = IDX_W'(MAX_ORDER);
    end else begin
      n_eff = IDX_W'(order);
    end
  end

  assign k_top = k_eff - KW'(1);

  // Single read port of the word store: scan pointer, extension source, or emit slot.
  always_comb begin
    unique case (state)
      ST_SCAN:   rd_addr = scan_ptr;
      ST_EXTEND: rd_addr = ext_j;
      default:   rd_addr = emit_index;
    endcase
  end

  assign rd_data    = word[rd_addr];
  assign at_max     = KW'(rd_data) >= k_top;
  // The extension source wraps at the word length; reaching n exactly on a wrap
  // means the length divides n.
  assign period_end = (ext_j == word_length);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    finish_ok   = 1'b0;
    finish_last = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept && (restart || emit_index >= word_length)) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!at_max) begin
          if (scan_ptr == n_eff) begin
            finish_ok  = 1'b1;
            state_next = ST_IDLE;
          end else begin
            state_next = ST_EXTEND;
          end
        end else if (scan_ptr == IDX_W'(1)) begin
          // no position left to increment: the cycle is complete
          finish_last = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      ST_EXTEND: begin
        if (ext_i == n_eff) begin
          if (period_end) begin
            finish_ok  = 1'b1;
            state_next = ST_IDLE;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
    if (cfg_wr) begin
      state_next  = ST_IDLE;
      finish_ok   = 1'b0;
      finish_last = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      alphabet_size  <= CFG_W'(2);
      order          <= CFG_W'(3);
      word_length    <= IDX_W'(1);
      emit_index     <= IDX_W'(1);
      position_count <= '0;
      m_tvalid       <= 1'b0;
      for (int e = 1; e <= MAX_ORDER; e++) begin
        word[e] <= '0;
      end
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (restart) begin
              // start over: symbol zero at position zero, then search the successor
              for (int e = 1; e <= MAX_ORDER; e++) begin
                word[e] <= '0;
              end
              word_length    <= IDX_W'(1);
              emit_index     <= IDX_W'(1);
              position_count <= '0;
              hold_symbol    <= '0;
              scan_ptr       <= n_eff;
            end else if (emit_index >= word_length) begin
              // last symbol of this word: hold it until the successor is known
              hold_symbol <= rd_data;
              scan_ptr    <= n_eff;
            end else begin
              m_tvalid       <= 1'b1;
              out_symbol     <= SYMBOL_W'(rd_data);
              out_pos        <= position_count;
              out_last       <= 1'b0;
              emit_index     <= emit_index + IDX_W'(1);
              position_count <= position_count + POS_W'(1);
            end
          end
        end
        ST_SCAN: begin
          if (!at_max) begin
            // increment here and truncate the word to this length
            word[scan_ptr] <= rd_data + WORD_W'(1);
            word_length    <= scan_ptr;
            ext_i          <= scan_ptr + IDX_W'(1);
            ext_j          <= IDX_W'(1);
          end else begin
            scan_ptr <= scan_ptr - IDX_W'(1);
          end
        end
        ST_EXTEND: begin
          // repeat the word periodically up to length n
          word[ext_i] <= rd_data;
          ext_i       <= ext_i + IDX_W'(1);
          ext_j       <= period_end ? IDX_W'(1) : ext_j + IDX_W'(1);
          if (ext_i == n_eff) begin
            scan_ptr <= n_eff;
          end
        end
        default: ;
      endcase

      if (finish_ok) begin
        m_tvalid       <= 1'b1;
        out_symbol     <= SYMBOL_W'(hold_symbol);
        out_pos        <= position_count;
        out_last       <= 1'b0;
        emit_index     <= IDX_W'(1);
        position_count <= position_count + POS_W'(1);
      end

      if (finish_last) begin
        m_tvalid       <= 1'b1;
        out_symbol     <= SYMBOL_W'(hold_symbol);
        out_pos        <= position_count;
        out_last       <= 1'b1;
        word_length    <= IDX_W'(1);
        emit_index     <= IDX_W'(1);
        position_count <= '0;
        for (int e = 1; e <= MAX_ORDER; e++) begin
          word[e] <= '0;
        end
      end

      // any register write also returns the sequence to position zero
      if (cfg_wr) begin
        unique case (cfg_index)
          REG_ALPHABET: alphabet_size <= pwdata[CFG_W-1:0];
          REG_ORDER:    order         <= pwdata[CFG_W-1:0];
          default: ;
        endcase
        word_length    <= IDX_W'(1);
        emit_index     <= IDX_W'(1);
        position_count <= '0;
        for (int e = 1; e <= MAX_ORDER; e++) begin
          word[e] <= '0;
        end
      end
    end
  end

  // Input is never taken while a successor search is running.
  a_ready_only_idle: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> (state == ST_IDLE))
    else $error("input taken while sequencer busy");

  // The current word never exceeds the window length; while idle the emit slot lies
  // inside the word (a search may shorten the word below the held emit slot).
  a_length_bound: assert property (@(posedge clk) disable iff (rst)
    (word_length != '0) && (word_length <= n_eff) &&
    ((state != ST_IDLE) || (emit_index <= word_length)))
    else $error("word length or emit index out of range");

  // A pending end-of-cycle word means the sequencer already wrapped to the start.
  a_wrap_after_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |->
      (position_count == '0) && (emit_index == IDX_W'(1)) && (word_length == IDX_W'(1)))
    else $error("sequence did not wrap after last symbol");

  // Extension only writes entries above the current length and up to n.
  a_extend_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXTEND) |-> (ext_i > word_length) && (ext_i <= n_eff))
    else $error("extension index out of range");

endmodule

// ===== tb/sv/de_bruijn_checker.sv =====
// Scoreboard for the de Bruijn sequence generator: tracks registers, predicts and checks symbols.
module de_bruijn_checker
  import dbsg_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // [0] restart, [7:1] zero
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic [M_TDATA_W-1:0] m_tdata,   // [2:0] symbol, [26:3] position, [31:27] zero
  input  logic                 m_tlast,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic                 pready,
  input  logic [APB_AW-1:0]    paddr,
  input  logic [APB_DW-1:0]    pwdata,
  output int                   fail_count = 0,
  output int                   pending = 0,
  output int                   checked = 0,
  output int                   wraps = 0
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [SYMBOL_W-1:0] symbol;
    logic [POS_W-1:0]    position;
    logic                last;
  } symbol_word_t;

  // shadow of the sequencer: current Lyndon word and emit pointers
  logic [WORD_W-1:0] lyndon [0:MAX_ORDER];
  int unsigned       word_len;
  int unsigned       emit_idx;
  logic [POS_W-1:0]  next_pos;
  logic [CFG_W-1:0]  alphabet_reg;
  logic [CFG_W-1:0]  order_reg;

  symbol_word_t expected_symbols[$];
  int errors   = 0;
  int n_checked = 0;
  int n_wraps  = 0;

  function automatic int unsigned symbols_in_use();
    int unsigned k;
    k = alphabet_reg;
    if (k < 2) k = 2;
    if (k > MAX_ALPHABET) k = MAX_ALPHABET;
    return k;
  endfunction

  function automatic int unsigned window_len();
    int unsigned n;
    n = order_reg;
    if (n < 1) n = 1;
    if (n > MAX_ORDER) n = MAX_ORDER;
    return n;
  endfunction

  function automatic void rewind_sequence();
    foreach (lyndon[i]) lyndon[i] = '0;
    word_len = 1;
    emit_idx = 1;
    next_pos = '0;
  endfunction

  // step to the next Lyndon word whose length divides n; 0 when the cycle is done
  function automatic bit advance_lyndon(int unsigned k, int unsigned n);
    int unsigned p;
    forever begin
      p = word_len;
      if (p < 1 || p > n) p = 1;
      for (int unsigned i = p + 1; i <= n; i++) lyndon[i] = lyndon[i - p];
      p = n;
      while (p > 0 && lyndon[p] >= k - 1) p--;
      if (p == 0) return 1'b0;
      lyndon[p] = lyndon[p] + 1'b1;
      word_len  = p;
      if (n % p == 0) return 1'b1;
    end
  endfunction

  function automatic symbol_word_t next_symbol(logic restart);
    symbol_word_t w;
    int unsigned  k;
    int unsigned  n;
    k = symbols_in_use();
    n = window_len();
    if (restart) rewind_sequence();
    if (word_len < 1 || word_len > n) word_len = 1;
    if (emit_idx < 1 || emit_idx > word_len) emit_idx = 1;
    w.symbol   = lyndon[emit_idx];
    w.position = next_pos;
    w.last     = 1'b0;
    if (emit_idx >= word_len) begin
      if (advance_lyndon(k, n)) begin
        emit_idx = 1;
        next_pos = next_pos + 1'b1;
      end else begin
        w.last = 1'b1;
        rewind_sequence();
      end
    end else begin
      emit_idx++;
      next_pos = next_pos + 1'b1;
    end
    return w;
  endfunction

  function automatic bit field_differs(string name, int unsigned want, int unsigned got);
    if (want == got) return 1'b0;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    return 1'b1;
  endfunction

  always @(posedge clk) begin : monitor
    symbol_word_t got;
    symbol_word_t want;
    bit           bad;
    if (rst) begin
      alphabet_reg = CFG_W'(2);
      order_reg    = CFG_W'(3);
      rewind_sequence();
      expected_symbols.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_index_t'(paddr[2]))
          REG_ALPHABET: alphabet_reg = pwdata[CFG_W-1:0];
          REG_ORDER:    order_reg    = pwdata[CFG_W-1:0];
        endcase
        rewind_sequence();
      end
      if (s_tvalid && s_tready) begin
        expected_symbols.insert(expected_symbols.size(), next_symbol(s_tdata[0]));
      end
      if (m_tvalid && m_tready) begin
        got.symbol   = m_tdata[SYMBOL_W-1:0];
        got.position = m_tdata[SYMBOL_W +: POS_W];
        got.last     = m_tlast;
        if (expected_symbols.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual symbol %0d position %0d last %0b",
                   $time, got.symbol, got.position, got.last);
          errors++;
        end else begin
          want = expected_symbols.pop_front();
          bad  = field_differs("symbol", want.symbol, got.symbol);
          bad |= field_differs("position", want.position, got.position);
          bad |= field_differs("last", want.last, got.last);
          if (bad) errors++;
          n_checked++;
          if (got.last) n_wraps++;
        end
      end
    end
    fail_count <= errors;
    pending    <= expected_symbols.size();
    checked    <= n_checked;
    wraps      <= n_wraps;
  end

endmodule

// ===== tb/sv/tb_de_bruijn_sequence_generator.sv =====
// Testbench top for the de Bruijn sequence generator: stimulus, flow control and verdict.
module tb_de_bruijn_sequence_generator;
  import dbsg_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WORD_TARGET  = 1950;
  // worst case per word is a long successor search plus a sparse receiver; this is many
  // times the slowest legal run
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 64;

  typedef enum {RDY_ALWAYS, RDY_RANDOM, RDY_PATTERN, RDY_SPARSE} ready_mode_t;

  logic                 clk      = 1'b0;
  logic                 rst      = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata  = '0;   // [0] restart, [7:1] zero
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;         // [2:0] symbol, [26:3] position, [31:27] zero
  logic                 m_tlast;
  logic                 psel     = 1'b0;
  logic                 penable  = 1'b0;
  logic                 pwrite   = 1'b0;
  logic [APB_AW-1:0]    paddr    = '0;
  logic [APB_DW-1:0]    pwdata   = '0;
  logic [APB_DW-1:0]    prdata;
  logic                 pready;

  int fail_count;
  int pending;
  int checked;
  int wraps;

  ready_mode_t      ready_mode   = RDY_ALWAYS;
  int unsigned      ready_tick   = 0;
  logic [CFG_W-1:0] alphabet_now = CFG_W'(2);
  logic [CFG_W-1:0] order_now    = CFG_W'(3);
  int               words_sent   = 0;
  int               settings_used = 1;

  de_bruijn_sequence_generator u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  de_bruijn_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked),
    .wraps      (wraps)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: a hung handshake or a lost word ends the run here.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Timed out after %0d cycles with %0d words outstanding", CYCLE_LIMIT, pending);
    $display("FAILURE");
    $finish;
  end

  // Receiver back-pressure. The mode is swapped per register setting so that stalls land
  // on every phase of the successor search; one mode never stalls at all.
  always @(negedge clk) begin
    ready_tick <= ready_tick + 1;
    case (ready_mode)
      RDY_ALWAYS:  m_tready <= 1'b1;
      RDY_RANDOM:  m_tready <= ($urandom_range(0, 9) < 7);
      RDY_PATTERN: m_tready <= ((ready_tick % 7) < 4);
      default:     m_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Offer one word and hold it until accepted; leave tvalid high so that back-to-back
  // words need no second assignment in the same step.
  task automatic send_word(logic restart);
    s_tvalid <= 1'b1;
    s_tdata  <= S_TDATA_W'(restart);
    do @(posedge clk); while (!s_tready);
    words_sent++;
    @(negedge clk);
  endtask

  // Drop tvalid and hold off until every predicted word is out and the sequencer has
  // finished its search (s_tready back high).
  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Register write: setup phase, then access phase; only ever done while idle.
  task automatic write_reg(reg_index_t idx, logic [CFG_W-1:0] value);
    settle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'(int'(idx) * 4);
    pwdata  <= APB_DW'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_ALPHABET) alphabet_now = value;
    else order_now = value;
  endtask

  // Cycle length k^n for the current registers, with the same clamping the block applies.
  function automatic int unsigned cycle_len();
    int unsigned k;
    int unsigned n;
    int unsigned len;
    k = (alphabet_now < 2) ? 2 : (alphabet_now > MAX_ALPHABET) ? MAX_ALPHABET : alphabet_now;
    n = (order_now < 1) ? 1 : (order_now > MAX_ORDER) ? MAX_ORDER : order_now;
    len = 1;
    repeat (n) len *= k;
    return len;
  endfunction

  // Stream a batch of words, in bursts with random gaps when gaps is set; restarts are
  // rare so most batches run whole cycles through the wrap. At pause_at the sender waits
  // for the pipeline to empty completely before carrying on.
  task automatic run_words(int count, bit gaps, int pause_at);
    int burst;
    burst = $urandom_range(1, 16);
    for (int i = 0; i < count; i++) begin
      if (i == pause_at) settle();
      send_word($urandom_range(0, 31) == 0);
      burst--;
      if (gaps && burst == 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
        burst = $urandom_range(1, 16);
      end
    end
  endtask

  initial begin : stimulus
    logic [CFG_W-1:0] extreme_alpha [5];
    logic [CFG_W-1:0] extreme_order [5];
    logic [CFG_W-1:0] new_alpha;
    logic [CFG_W-1:0] new_order;
    int unsigned      len;
    int               count;
    int               pick;
    int               phase;

    extreme_alpha = '{CFG_W'(8), CFG_W'(2), CFG_W'(8), CFG_W'(0), CFG_W'(15)};
    extreme_order = '{CFG_W'(8), CFG_W'(8), CFG_W'(1), CFG_W'(15), CFG_W'(0)};
    phase = 0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: reset defaults (k=2, n=3) run past the wrap, then a restart mid-cycle.
    repeat (9) send_word(1'b0);
    send_word(1'b0);
    send_word(1'b1);
    // Registers below range clamp to k=2, n=1; the write also lands mid-cycle.
    write_reg(REG_ALPHABET, CFG_W'(0));
    write_reg(REG_ORDER, CFG_W'(0));
    repeat (3) send_word(1'b0);
    // Alphabet above range clamps to 8: every symbol value 0..7 shows up, then wraps.
    write_reg(REG_ALPHABET, CFG_W'(15));
    write_reg(REG_ORDER, CFG_W'(1));
    repeat (9) send_word(1'b0);
    // Order above range clamps to 8, alphabet 1 clamps to 2.
    write_reg(REG_ORDER, CFG_W'(15));
    write_reg(REG_ALPHABET, CFG_W'(1));
    repeat (2) send_word(1'b0);
    settings_used += 3;

    // Random: mostly small alphabets and orders so cycles wrap several times, now and
    // then the extremes, where the longer cycles are streamed only in part.
    while (words_sent < WORD_TARGET) begin
      pick = $urandom_range(0, 9);
      if (pick < 2) begin
        pick      = $urandom_range(0, 4);
        new_alpha = extreme_alpha[pick];
        new_order = extreme_order[pick];
      end else if (pick < 4) begin
        new_alpha = CFG_W'($urandom_range(2, 8));
        new_order = CFG_W'($urandom_range(1, 3));
      end else begin
        new_alpha = CFG_W'($urandom_range(2, 4));
        new_order = CFG_W'($urandom_range(1, 4));
      end

      // Vary which registers get written and in what order.
      case ($urandom_range(0, 3))
        0: begin
          write_reg(REG_ALPHABET, new_alpha);
          write_reg(REG_ORDER, new_order);
        end
        1: begin
          write_reg(REG_ORDER, new_order);
          write_reg(REG_ALPHABET, new_alpha);
        end
        2: write_reg(REG_ALPHABET, new_alpha);
        default: write_reg(REG_ORDER, new_order);
      endcase
      settings_used++;
      ready_mode = ready_mode_t'($urandom_range(0, 3));

      len   = cycle_len();
      count = (len < 150) ? int'(len + $urandom_range(1, len)) : int'($urandom_range(30, 80));
      if (count > WORD_TARGET - words_sent + 20) count = WORD_TARGET - words_sent + 20;
      // The first batch always drains fully halfway through; later ones sometimes.
      run_words(count, $urandom_range(0, 3) != 0,
                (phase == 0 || $urandom_range(0, 3) == 0) ? count / 2 : -1);
      phase++;
    end

    // Let everything drain, then watch a while longer for stray words.
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d symbols from %0d input words over %0d register settings",
             checked, words_sent, settings_used);
    $display("Saw %0d cycle wraps, with restarts, clamped registers and stalls on both sides",
             wraps);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/dbsg_pkg.sv
rtl/de_bruijn_sequence_generator.sv
tb/sv/de_bruijn_checker.sv
tb/sv/tb_de_bruijn_sequence_generator.sv
